FILE: hw/rtl/lifo_stack_with_search_core_macros.svh
// assertion macros used by the lifo stack controller
`ifndef LIFO_STACK_WITH_SEARCH_CORE_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define LIFOSTK_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lifostk assertion failed");

// next-cycle implication, disabled during reset
`define LIFOSTK_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lifostk assertion failed");

`else

`define LIFOSTK_ASSERT_IMP(label, ante, cons)
`define LIFOSTK_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/lifostk_pkg.sv
// package with sizes, codes and shared types of the lifo stack
package lifostk_pkg;

    localparam int DEPTH  = 256;
    localparam int DATA_W = 32;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // operation codes
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // request from the controller to the entry memory
    typedef struct packed {
        logic                     we;
        logic [PTR_W-1:0]         waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [PTR_W-1:0]         raddr;
    } ram_req_t;

    // low 9 bits of an entry count
    function automatic logic [8:0] count_out(input logic [CNT_W-1:0] c);
        logic [CNT_W+8:0] wide;
        wide = {{9{1'b0}}, c};
        return wide[8:0];
    endfunction

    // low 8 bits of a search distance
    function automatic logic [7:0] pos_out(input logic [PTR_W-1:0] d);
        logic [PTR_W+7:0] wide;
        wide = {{8{1'b0}}, d};
        return wide[7:0];
    endfunction

endpackage

FILE: hw/rtl/lifostk_ram.sv
// generic simple dual-port ram with registered read
module lifostk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/lifostk_ctrl.sv
// stack controller: count, search sequencer and result register
`include "lifo_stack_with_search_core_macros.svh"

module lifostk_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_kind,
    input  logic signed [lifostk_pkg::DATA_W-1:0] s_push_value,
    input  logic signed [lifostk_pkg::DATA_W-1:0] s_search_key,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [7:0]                        m_found_position,
    output logic [8:0]                        m_entry_count,
    output lifostk_pkg::ram_req_t             ram_req,
    input  logic signed [lifostk_pkg::DATA_W-1:0] ram_rdata
);
    import lifostk_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [PTR_W-1:0]          dist_reg, dist_next;
    logic signed [DATA_W-1:0]  key_reg, key_next;
    logic                      m_valid_reg, m_valid_next;
    logic [1:0]                status_reg, status_next;
    logic [7:0]                pos_reg, pos_next;
    logic [8:0]                cnt_out_reg, cnt_out_next;
    logic [PTR_W-1:0]          top_ptr;
    logic                      accept;

    // index of the top entry, valid when the stack is not empty
    assign top_ptr = PTR_W'(count_reg - CNT_W'(1));
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // next state, memory requests and result
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        dist_next     = dist_reg;
        key_next      = key_reg;
        m_valid_next  = m_valid_reg;
        status_next   = status_reg;
        pos_next      = pos_reg;
        cnt_out_next  = cnt_out_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = count_reg[PTR_W-1:0];
        ram_req.wdata = s_push_value;
        ram_req.raddr = (state_reg == S_IDLE) ? top_ptr : top_ptr - dist_reg - PTR_W'(1);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    m_valid_next = 1'b1;
                    status_next  = ST_DONE;
                    pos_next     = '0;
                    cnt_out_next = count_out(count_reg);
                    case (s_kind)
                        OP_PUSH: begin
                            if (count_reg == CNT_W'(DEPTH)) begin
                                status_next = ST_FULL;
                            end else begin
                                ram_req.we   = 1'b1;
                                count_next   = count_reg + CNT_W'(1);
                                cnt_out_next = count_out(count_reg + CNT_W'(1));
                            end
                        end
                        OP_POP: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                count_next   = count_reg - CNT_W'(1);
                                cnt_out_next = count_out(count_reg - CNT_W'(1));
                            end
                        end
                        OP_SEARCH: begin
                            if (count_reg == '0) begin
                                status_next = ST_NOT_FOUND;
                            end else begin
                                // top entry read is issued this cycle
                                m_valid_next = 1'b0;
                                key_next     = s_search_key;
                                dist_next    = '0;
                                state_next   = S_SEARCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // compare the entry read for the current distance
                if (ram_rdata == key_reg) begin
                    m_valid_next = 1'b1;
                    status_next  = ST_DONE;
                    pos_next     = pos_out(dist_reg);
                    cnt_out_next = count_out(count_reg);
                    state_next   = S_IDLE;
                end else if (dist_reg == top_ptr) begin
                    m_valid_next = 1'b1;
                    status_next  = ST_NOT_FOUND;
                    pos_next     = '0;
                    cnt_out_next = count_out(count_reg);
                    state_next   = S_IDLE;
                end else begin
                    dist_next = dist_reg + PTR_W'(1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        dist_reg    <= dist_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_found_position = pos_reg;
    assign m_entry_count    = cnt_out_reg;

    // checks
    `LIFOSTK_ASSERT_IMP(a_no_accept_in_search, state_reg == S_SEARCH, !s_ready)
    `LIFOSTK_ASSERT_IMP(a_no_result_in_search, state_reg == S_SEARCH, !m_valid_reg)
    `LIFOSTK_ASSERT_IMP(a_count_bounded, 1'b1, count_reg <= CNT_W'(DEPTH))
    `LIFOSTK_ASSERT_NXT(a_full_push_keeps_count, accept && s_kind == OP_PUSH && count_reg == CNT_W'(DEPTH), $stable(count_reg))

endmodule

FILE: hw/rtl/lifo_stack_with_search_core.sv
// top level of the lifo stack with linear search
// Usage: one input channel (s_) carries a transaction with an operation
// kind (0 push, 1 pop, 2 search, 3 no operation), a push value and a search
// key; one result channel (m_) returns a status, a found position and the
// entry count after the operation, one result per input transaction.
// Entries live in a single ram with one write and one registered read port.
// Push, pop, no-op and a search of an empty stack give their result in the
// cycle after acceptance. A search reads one entry per cycle from the top
// down through the ram read port and ends at the first match or, with a
// not-found status, once the bottom entry has been compared.
// Throughput: one transaction per cycle for push and pop while the result
// is taken; a search holds s_ready low until it completes.
// Reset (aresetn low, synchronous) empties the stack and drops any pending
// result; ram contents are left as they are and never used before written.
// When the receiver stalls, the result stays in its output register and
// s_ready drops until the result is taken or taken in the same cycle.
module lifo_stack_with_search_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_kind,
    input  logic signed [lifostk_pkg::DATA_W-1:0] s_push_value,
    input  logic signed [lifostk_pkg::DATA_W-1:0] s_search_key,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_status,
    output logic [7:0]                            m_found_position,
    output logic [8:0]                            m_entry_count
);
    import lifostk_pkg::*;

    ram_req_t                 ram_req;
    logic [DATA_W-1:0]        ram_rdata;

    // controller
    lifostk_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_push_value     (s_push_value),
        .s_search_key     (s_search_key),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_entry_count    (m_entry_count),
        .ram_req          (ram_req),
        .ram_rdata        (ram_rdata)
    );

    // entry storage
    lifostk_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule
